### src/pig_pkg.sv
`timescale 1ns / 1ps
package pig_pkg;

   localparam int MAX_VARS_DEF = 4;
   localparam int ROWS_MAX     = 16;
   localparam int RESULT_CAP   = 32;

   typedef struct packed {
      logic [3:0] row_index;
      logic       truth_bit;
      logic       last_row;
   } req_type;

   typedef struct packed {
      logic [3:0] care_mask;
      logic [3:0] cube_value;
      logic       empty_function;
      logic       last_prime;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT,
      ST_EMPTY,
      ST_CLEAR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic store_row;
      logic scan_start;
      logic scan_step;
      logic clear_table;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic scan_done;
      logic hit;
      logic any_minterm;
   } status_type;

   // popcount of a nibble
   function automatic logic [2:0] ones4(input logic [3:0] v);
      ones4 = {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
   endfunction

endpackage

### src/pig_datapath.sv
`timescale 1ns / 1ps
module pig_datapath #(
   parameter int MAX_VARS = pig_pkg::MAX_VARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         num_vars,
   input  pig_pkg::req_type   req_data,
   input  pig_pkg::cmd_type   cmd,
   output pig_pkg::status_type status,
   output logic [3:0]         hit_mask,
   output logic [3:0]         hit_value
);
   localparam int ROWS = 1 << MAX_VARS;

   logic [ROWS-1:0] truth_ff, truth_in;
   // scan position: ones count, mask, value
   logic [2:0] ones_ff, ones_in;
   logic [3:0] mask_ff, mask_in, value_ff, value_in;
   logic [2:0] nv;
   logic [4:0] rows;
   logic [3:0] lim;
   logic       imp, merged, prime, valid_cube, wrap_v, wrap_m, done;

   // effective variable count
   always_comb begin
      nv = num_vars;
      if (nv == 3'd0) nv = 3'd1;
      if (nv > 3'(MAX_VARS)) nv = 3'(MAX_VARS);
      rows = 5'd1 << nv;
      lim  = 4'(rows - 5'd1);
   end

   // implicant test of a cube against the table
   function automatic logic is_imp(input logic [3:0] m, input logic [3:0] v,
                                   input logic [ROWS-1:0] t, input logic [4:0] r);
      logic ok;
      ok = 1'b1;
      for (int k = 0; k < ROWS; k++) begin
         if (5'(k) < r && ((4'(k) & m) == v) && !t[k]) ok = 1'b0;
      end
      return ok;
   endfunction

   // primality of the current cube
   always_comb begin
      valid_cube = ((value_ff & ~mask_ff) == 4'd0) && (pig_pkg::ones4(value_ff) == ones_ff);
      imp    = is_imp(mask_ff, value_ff, truth_ff, rows);
      merged = 1'b0;
      for (int i = 0; i < MAX_VARS; i++) begin
         if (mask_ff[i] && 3'(i) < nv &&
             is_imp(mask_ff & ~(4'd1 << i), value_ff & ~(4'd1 << i), truth_ff, rows))
            merged = 1'b1;
      end
      prime = valid_cube && imp && !merged;
      wrap_v = (value_ff == lim);
      wrap_m = (mask_ff == lim);
      done   = wrap_v && wrap_m && (ones_ff == nv);
   end

   // table store and scan counters
   always_comb begin
      truth_in = truth_ff;
      ones_in  = ones_ff;
      mask_in  = mask_ff;
      value_in = value_ff;
      if (cmd.clear_table) truth_in = '0;
      if (cmd.store_row && {1'b0, req_data.row_index} < rows)
         truth_in[req_data.row_index[MAX_VARS-1:0]] = req_data.truth_bit;
      if (cmd.scan_start) begin
         ones_in = 3'd0; mask_in = 4'd0; value_in = 4'd0;
      end else if (cmd.scan_step && !done) begin
         if (!wrap_v) value_in = value_ff + 4'd1;
         else begin
            value_in = 4'd0;
            if (!wrap_m) mask_in = mask_ff + 4'd1;
            else begin
               mask_in = 4'd0;
               ones_in = ones_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) truth_ff <= '0;
      else truth_ff <= truth_in;
      ones_ff  <= ones_in;
      mask_ff  <= mask_in;
      value_ff <= value_in;
   end

   assign status.scan_done   = done;
   assign status.hit         = prime;
   assign status.any_minterm = |(truth_ff & ((ROWS)'((17'd1 << rows) - 17'd1)));
   assign hit_mask  = mask_ff;
   assign hit_value = value_ff;
endmodule

### src/pig_controller.sv
`timescale 1ns / 1ps
module pig_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pig_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pig_pkg::rsp_type   rsp_data,
   output pig_pkg::cmd_type   cmd,
   input  pig_pkg::status_type status,
   input  logic [3:0]         hit_mask,
   input  logic [3:0]         hit_value
);
   pig_pkg::state_type state_ff, state_in;
   // one found prime waits here until the next is found or the scan ends
   logic       held_ff, held_in;
   logic [3:0] hmask_ff, hmask_in, hval_ff, hval_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       ov_ff, ov_in;
   pig_pkg::rsp_type out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pig_pkg::ST_LOAD;
         held_ff  <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
         ov_ff    <= ov_in;
      end
      hmask_ff <= hmask_in;
      hval_ff  <= hval_in;
      cnt_ff   <= cnt_in;
      out_ff   <= out_in;
   end

   always_comb begin
      logic out_free;
      out_free  = !ov_ff || rsp_ready;
      state_in  = state_ff;
      held_in   = held_ff;
      hmask_in  = hmask_ff;
      hval_in   = hval_ff;
      cnt_in    = cnt_ff;
      ov_in     = ov_ff && !rsp_ready;
      out_in    = out_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         pig_pkg::ST_LOAD: begin
            // rows load while a final result still drains
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store_row = 1'b1;
               if (req_data.last_row) begin
                  cmd.scan_start = 1'b1;
                  held_in  = 1'b0;
                  cnt_in   = 6'd0;
                  state_in = pig_pkg::ST_SCAN;
               end
            end
         end
         pig_pkg::ST_SCAN: begin
            if (!status.any_minterm) state_in = pig_pkg::ST_EMPTY;
            else if (status.hit && held_ff && !out_free) begin
               // wait for output slot
            end else begin
               cmd.scan_step = 1'b1;
               if (status.hit) begin
                  if (held_ff && cnt_ff < 6'(pig_pkg::RESULT_CAP)) begin
                     out_in = '{hmask_ff, hval_ff, 1'b0, 1'b0};
                     ov_in  = 1'b1;
                     cnt_in = cnt_ff + 6'd1;
                  end
                  held_in  = 1'b1;
                  hmask_in = hit_mask;
                  hval_in  = hit_value;
               end
               if (status.scan_done) state_in = pig_pkg::ST_EMIT;
            end
         end
         pig_pkg::ST_EMIT: begin
            // final prime carries the last flag
            if (out_free) begin
               out_in   = '{hmask_ff, hval_ff, 1'b0, 1'b1};
               ov_in    = 1'b1;
               state_in = pig_pkg::ST_CLEAR;
            end
         end
         pig_pkg::ST_EMPTY: begin
            if (out_free) begin
               out_in   = '{4'd0, 4'd0, 1'b1, 1'b1};
               ov_in    = 1'b1;
               state_in = pig_pkg::ST_CLEAR;
            end
         end
         pig_pkg::ST_CLEAR: begin
            cmd.clear_table = 1'b1;
            state_in = pig_pkg::ST_LOAD;
         end
         default: state_in = pig_pkg::ST_LOAD;
      endcase
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;
endmodule

### src/prime_implicant_generator.sv
`timescale 1ns / 1ps
// Quine-McCluskey prime implicant generator.
// req_ channel: one truth table row per transaction (row_index, truth_bit,
//   last_row). Rows load one per cycle between searches; rows past 2^n are
//   dropped (n is num_vars clamped to 1..MAX_VARS). A transaction with
//   last_row set starts the prime search, which walks every (ones, mask,
//   value) position, one per cycle unless a result stall holds it. It then
//   sends the final prime and clears the table store before req_ready
//   returns; a function with no minterms sends the empty result instead.
// rsp_ channel: one transaction per prime, ordered by ones count, mask,
//   value; last_prime marks the end. A function with no minterms returns a
//   single transaction with empty_function set.
// csr_ channel: writes num_vars; write only while idle.
// The result register holds one prime; when rsp_ready is low the search
//   pauses at the next prime found until the register drains. The input is
//   not taken during a search, but rows of the next table load while the
//   final prime still waits.
// Reset clears the table store and the state machine and sets num_vars to 4.
module prime_implicant_generator #(
   parameter int MAX_VARS = pig_pkg::MAX_VARS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pig_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pig_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_data
);
   logic [2:0] num_vars_ff;
   pig_pkg::cmd_type    cmd;
   pig_pkg::status_type status;
   logic [3:0] hit_mask, hit_value;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) num_vars_ff <= 3'd4;
      else if (csr_valid) num_vars_ff <= csr_data;
   end

   pig_datapath #(.MAX_VARS(MAX_VARS)) u_dp (
      .clock, .reset, .num_vars(num_vars_ff), .req_data, .cmd, .status,
      .hit_mask, .hit_value
   );

   pig_controller u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid,
      .rsp_ready, .rsp_data, .cmd, .status, .hit_mask, .hit_value
   );

   // held result stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");
   // input only taken between searches
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> u_ctl.state_ff == pig_pkg::ST_LOAD)
      else $error("input accepted during search");
   // empty flag only on a final transaction
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_function |-> rsp_data.last_prime)
      else $error("empty result not last");
endmodule

### tb/tb_prime_implicant_generator.sv
`timescale 1ns / 1ps
module tb_prime_implicant_generator;

   localparam int WATCHDOG_LIMIT = 20000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   pig_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   pig_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [2:0]       csr_data = '0;

   // predictor state
   logic [2:0]  vars_reg = 3'd4;
   logic [15:0] table_bits = '0;

   pig_pkg::req_type pending_rows[$];
   pig_pkg::rsp_type primes_due[$];
   int  error_count = 0;
   int  idle_cycles = 0;
   bit  quiet_mode = 1'b0;
   bit  rx_hold = 1'b0;
   bit  tx_pause = 1'b0;

   prime_implicant_generator dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   // true when every row covered by the cube is a minterm
   function automatic bit is_implicant(input int n, input logic [3:0] mask,
                                       input logic [3:0] value);
      for (int m = 0; m < (1 << n); m++)
         if ((m[3:0] & mask) == value && !table_bits[m]) return 1'b0;
      return 1'b1;
   endfunction

   // apply one row and queue the primes it produces
   task automatic predict_primes(input pig_pkg::req_type r);
      int n;
      int rows;
      int count;
      bit prime;
      pig_pkg::rsp_type res;
      n = (vars_reg == 0) ? 1 : (vars_reg > 4) ? 4 : int'(vars_reg);
      rows = 1 << n;
      count = 0;
      if (r.row_index < rows) table_bits[r.row_index] = r.truth_bit;
      if (!r.last_row) return;
      if ((table_bits & ((1 << rows) - 1)) == 0) begin
         res = '{care_mask: 4'd0, cube_value: 4'd0, empty_function: 1'b1,
                 last_prime: 1'b1};
         primes_due = {primes_due, res};
      end else begin
         for (int ones = 0; ones <= n; ones++)
            for (int mk = 0; mk < rows; mk++)
               for (int v = 0; v < rows; v++) begin
                  if ((v & ~mk) != 0 || $countones(v[3:0]) != ones) continue;
                  if (!is_implicant(n, mk[3:0], v[3:0])) continue;
                  prime = 1'b1;
                  for (int i = 0; i < n; i++)
                     if (mk[i] && is_implicant(n, mk[3:0] & ~(4'd1 << i),
                                               v[3:0] & ~(4'd1 << i)))
                        prime = 1'b0;
                  if (prime && count < pig_pkg::RESULT_CAP) begin
                     res = '{care_mask: mk[3:0], cube_value: v[3:0],
                             empty_function: 1'b0, last_prime: 1'b0};
                     primes_due = {primes_due, res};
                     count++;
                  end
               end
         primes_due[$].last_prime = 1'b1;
      end
      table_bits = '0;
   endtask

   // driver: offers rows from the pending queue
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) predict_primes(req_data);
         if (!(req_valid && !req_ready)) begin
            if (pending_rows.size() > 0 && !tx_pause &&
                (quiet_mode || $urandom_range(99) >= 11)) begin
               req_data  <= pending_rows.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (primes_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected prime: got %p", rsp_data);
            end else begin
               if (rsp_data !== primes_due[0]) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("prime mismatch: expected %p got %p",
                              primes_due[0], rsp_data);
               end
               void'(primes_due.pop_front());
            end
         end
         rsp_ready <= !rx_hold && (quiet_mode || $urandom_range(99) >= 11);
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_prime_implicant_generator failed");
         $finish;
      end
   end

   function automatic pig_pkg::req_type make_row(input int r, input bit b, input bit l);
      pig_pkg::req_type t;
      t.row_index = r[3:0];
      t.truth_bit = b;
      t.last_row  = l;
      return t;
   endfunction

   // append one row to the pending queue
   function automatic void add_row(input pig_pkg::req_type t);
      pending_rows = {pending_rows, t};
   endfunction

   task automatic wait_drained();
      while (pending_rows.size() > 0 || req_valid || primes_due.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_vars(input logic [2:0] v);
      csr_data  <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      vars_reg = v;
   endtask

   // whole table with random content, then the last-row transaction
   task automatic queue_table(input int n, input int density);
      int rows;
      rows = 1 << n;
      for (int r = 0; r < rows - 1; r++)
         add_row(make_row(r, $urandom_range(99) < density, 1'b0));
      add_row(make_row(rows - 1, $urandom_range(99) < density, 1'b1));
   endtask

   initial begin
      logic [2:0] vars_plan[6];
      vars_plan = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: constant false, constant true, single minterms, out of range rows
      add_row(make_row(15, 1'b0, 1'b1));
      for (int r = 0; r < 16; r++) add_row(make_row(r, 1'b1, r == 15));
      add_row(make_row(5, 1'b1, 1'b1));
      wait_drained();
      write_vars(3'd2);
      add_row(make_row(9, 1'b1, 1'b0));
      add_row(make_row(3, 1'b1, 1'b0));
      add_row(make_row(12, 1'b1, 1'b1));
      wait_drained();

      // random phases across variable counts, including out of range values
      for (int p = 0; p < 6; p++) begin
         write_vars(vars_plan[p]);
         quiet_mode = (p == 2);
         for (int k = 0; k < 2; k++) begin
            int n;
            n = (vars_reg == 0) ? 1 : (vars_reg > 4) ? 4 : int'(vars_reg);
            if ($urandom_range(9) == 0)
               add_row(make_row($urandom_range(15), $urandom_range(1),
                                $urandom_range(1)));
            queue_table(n, $urandom_range(100));
         end
         if (p == 1) begin
            // receiver holds off while rows keep coming
            rx_hold = 1'b1;
            queue_table(4, 70);
            queue_table(4, 50);
            repeat (300) @(posedge clock);
            rx_hold = 1'b0;
         end
         if (p == 3) begin
            // sender pauses until every prime is back
            while (pending_rows.size() > 0) @(posedge clock);
            tx_pause = 1'b1;
            while (req_valid || primes_due.size() > 0) @(posedge clock);
            tx_pause = 1'b0;
         end
         wait_drained();
      end
      // last row left pending so every table is finished
      add_row(make_row(0, 1'b0, 1'b1));
      wait_drained();

      if (error_count == 0)
         $display("tb_prime_implicant_generator passed");
      else
         $display("tb_prime_implicant_generator failed");
      $finish;
   end
endmodule
